// ===== sv/bsdp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsdp_pkg
// Shared widths, command and status types for the block-scaled int8 dot
// product.
// ----------------------------------------------------------------------------
package bsdp_pkg;

  localparam int LANES      = 4;
  localparam int ELEM_W     = 8;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int LSUM_W     = PROD_W + $clog2(LANES);
  localparam int SCALE_W    = 16;
  localparam int PART_W     = 32;
  localparam int TERM_W     = 64;
  localparam int ACC_W      = 63;
  localparam int SUM_W      = ACC_W + 2;
  localparam int IN_DATA_W  = 2 * LANES * ELEM_W + 2 * SCALE_W;
  localparam int OUT_DATA_W = 64;

  localparam int ROW_SCALE_LSB = 2 * LANES * ELEM_W;
  localparam int COL_SCALE_LSB = ROW_SCALE_LSB + SCALE_W;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture item, lane sum and scale product
    logic part;   // update block partial sum
    logic mult;   // scale the closed block
    logic acc;    // accumulate, emit on dot end
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic close;     // current item ends a block
    logic dot_end;   // current item ends the dot product
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// ===== sv/bsdp_datapath.sv =====
// ----------------------------------------------------------------------------
// bsdp_datapath
// Lane products, saturating block partial sum, block scaling multiplier,
// saturating dot accumulator and output register.
// ----------------------------------------------------------------------------
module bsdp_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bsdp_pkg::cmd_t                   cmd_i,
  output bsdp_pkg::sts_t                   sts_o,
  input  logic [bsdp_pkg::IN_DATA_W-1:0]   in_data_i,
  input  logic                             in_block_end_i,
  input  logic                             in_dot_end_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bsdp_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic                             out_sat_o
);

  localparam int PW = bsdp_pkg::PART_W;
  localparam int SW = bsdp_pkg::SUM_W;
  localparam int AW = bsdp_pkg::ACC_W;

  localparam logic signed [PW:0] PART_MAX = (PW+1)'({1'b0, {(PW-1){1'b1}}});
  localparam logic signed [PW:0] PART_MIN = -PART_MAX - (PW+1)'(1);
  localparam logic signed [SW-1:0] ACC_MAX = SW'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX - SW'(1);

  logic signed [bsdp_pkg::ELEM_W-1:0] lane_a [bsdp_pkg::LANES];
  logic signed [bsdp_pkg::ELEM_W-1:0] lane_b [bsdp_pkg::LANES];
  logic signed [bsdp_pkg::PROD_W-1:0] lane_p [bsdp_pkg::LANES];
  logic signed [bsdp_pkg::LSUM_W-1:0] lane_sum;

  logic signed [bsdp_pkg::LSUM_W-1:0]    lsum_q;
  logic [2*bsdp_pkg::SCALE_W-1:0]        scale_q;
  logic                                  bend_q, dend_q;
  logic signed [PW-1:0]                  partial_q, partial_d;
  logic [PW-1:0]                         mag_q;
  logic                                  neg_q;
  logic [bsdp_pkg::TERM_W-1:0]           prod_q;
  logic signed [AW-1:0]                  acc_q, acc_d;
  logic                                  clip_q, clip_d;
  logic                                  out_valid_q, out_valid_d;
  logic signed [AW-1:0]                  out_val_q;
  logic                                  out_sat_q;

  logic signed [PW:0]   p_sum, p_sat;
  logic                 p_clip;
  logic [PW:0]          p_abs;
  logic signed [SW-1:0] term, a_sum, a_sat;
  logic                 a_clip;

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < bsdp_pkg::LANES; i++) begin
      lane_a[i] = in_data_i[i*bsdp_pkg::ELEM_W +: bsdp_pkg::ELEM_W];
      lane_b[i] = in_data_i[(bsdp_pkg::LANES+i)*bsdp_pkg::ELEM_W +: bsdp_pkg::ELEM_W];
      lane_p[i] = bsdp_pkg::PROD_W'(lane_a[i]) * bsdp_pkg::PROD_W'(lane_b[i]);
      lane_sum  = lane_sum + bsdp_pkg::LSUM_W'(lane_p[i]);
    end
  end

  // block partial sum
  always_comb begin
    p_sum  = (PW+1)'(partial_q) + (PW+1)'(lsum_q);
    p_clip = 1'b0;
    p_sat  = p_sum;
    if (p_sum > PART_MAX) begin
      p_sat  = PART_MAX;
      p_clip = 1'b1;
    end else if (p_sum < PART_MIN) begin
      p_sat  = PART_MIN;
      p_clip = 1'b1;
    end
    p_abs = p_sat[PW] ? (PW+1)'(-p_sat) : (PW+1)'(p_sat);
  end

  // dot accumulator
  always_comb begin
    term   = neg_q ? -SW'({1'b0, prod_q}) : SW'({1'b0, prod_q});
    a_sum  = SW'(acc_q) + term;
    a_clip = 1'b0;
    a_sat  = a_sum;
    if (a_sum > ACC_MAX) begin
      a_sat  = ACC_MAX;
      a_clip = 1'b1;
    end else if (a_sum < ACC_MIN) begin
      a_sat  = ACC_MIN;
      a_clip = 1'b1;
    end
  end

  always_comb begin
    partial_d   = partial_q;
    acc_d       = acc_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.part) begin
      partial_d = (bend_q || dend_q) ? '0 : PW'(p_sat);
      clip_d    = clip_q || p_clip;
    end
    if (cmd_i.acc) begin
      if (dend_q) begin
        acc_d       = '0;
        clip_d      = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        acc_d  = AW'(a_sat);
        clip_d = clip_q || a_clip;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      bend_q      <= 1'b0;
      dend_q      <= 1'b0;
    end else begin
      partial_q   <= partial_d;
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.load) begin
        bend_q <= in_block_end_i;
        dend_q <= in_dot_end_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lsum_q  <= lane_sum;
      scale_q <= (2*bsdp_pkg::SCALE_W)'(in_data_i[bsdp_pkg::ROW_SCALE_LSB +: bsdp_pkg::SCALE_W])
               * (2*bsdp_pkg::SCALE_W)'(in_data_i[bsdp_pkg::COL_SCALE_LSB +: bsdp_pkg::SCALE_W]);
    end
    if (cmd_i.part) begin
      mag_q <= PW'(p_abs);
      neg_q <= p_sat[PW];
    end
    if (cmd_i.mult) begin
      prod_q <= bsdp_pkg::TERM_W'(mag_q) * bsdp_pkg::TERM_W'(scale_q);
    end
    if (cmd_i.acc && dend_q) begin
      out_val_q <= AW'(a_sat);
      out_sat_q <= clip_q || a_clip;
    end
  end

  assign sts_o.close    = bend_q || dend_q;
  assign sts_o.dot_end  = dend_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = bsdp_pkg::OUT_DATA_W'({1'b0, out_val_q});
  assign out_sat_o   = out_sat_q;

endmodule

// ===== sv/bsdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsdp_ctrl
// Sequencer: accept, partial update, block scaling, accumulate.
// ----------------------------------------------------------------------------
module bsdp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bsdp_pkg::sts_t sts_i,
  output bsdp_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PART = 2'd1;
  localparam logic [1:0] ST_MULT = 2'd2;
  localparam logic [1:0] ST_ACC  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = ST_PART;
      end
      ST_PART: begin
        cmd_o.part = 1'b1;
        state_d    = sts_i.close ? ST_MULT : ST_IDLE;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        // on dot end, hold until the output register has room for the result
        if (!sts_i.dot_end || sts_i.out_free) begin
          cmd_o.acc = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== sv/block_scaled_int8_dot_product_top.sv =====
// ----------------------------------------------------------------------------
// block_scaled_int8_dot_product_top
// Block-scaled int8 dot product with Q1.15 row and column scales.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                               | tuser     | tlast
//  s_axis   | in  | a_lane0..3, b_lane0..3, row, col    | block_end | dot_end
//  m_axis   | out | dot_value (63b, 30 frac bits)       | saturated | -
//
//  An item without block end or dot end goes through accept and partial update.
//  An item closing a block goes through accept, partial update,
//  32x32 scale multiply and accumulate.
//  A dot result waits in the output register; the next dot end holds in
//  the accumulate step until that register is taken.
//  Reset clears partial sum, accumulator, clip flag and output valid.
// ----------------------------------------------------------------------------
module block_scaled_int8_dot_product_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // a_lane0..3, b_lane0..3, row_scale, col_scale
  input  logic        s_axis_tuser,   // block_end
  input  logic        s_axis_tlast,   // dot_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // dot_value, one pad bit
  output logic        m_axis_tuser    // saturated
);

  bsdp_pkg::cmd_t cmd;
  bsdp_pkg::sts_t sts;

  bsdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsdp_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_data_i      (s_axis_tdata),
    .in_block_end_i (s_axis_tuser),
    .in_dot_end_i   (s_axis_tlast),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_sat_o      (m_axis_tuser)
  );

endmodule

// ===== sv/bsdp_checker.sv =====
// ----------------------------------------------------------------------------
// bsdp_checker
// Port-level checks on item timing and output hold.
// ----------------------------------------------------------------------------
module bsdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input ready right after an item");

  a_plain_item_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !s_axis_tuser && !s_axis_tlast |-> ##2 s_axis_tready)
    else $error("item without block end not done in two cycles");

  a_dot_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast && !m_axis_tvalid |-> ##4 m_axis_tvalid)
    else $error("dot result missing four cycles after dot end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind block_scaled_int8_dot_product_top bsdp_checker u_bsdp_checker (.*);
